/* rtl/core/lttb_pkg.sv */
// Package for the local time to beat time converter.
// Holds field widths, register index codes, the month table and the
// reciprocal constants used by the top level and the beat stage.
package lttb_pkg;

  // Field widths of the input and result transactions.
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DomW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned MsW      = 10;
  localparam int unsigned DayW     = 9;
  localparam int unsigned BeatW    = 10;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Millisecond of day, up to one day plus out-of-range seconds and milliseconds.
  localparam int unsigned TimeW    = 27;

  // Register index codes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEST_OFFSET = 2'd0,
    CFG_DST_ACTIVE  = 2'd1,
    CFG_PLUS_ONE    = 2'd2
  } cfg_index_e;

  // Year mod 25 through a reciprocal: floor(y * Recip25 / 2^Recip25Sh).
  localparam logic [15:0] Recip25   = 16'd41943;
  localparam int unsigned Recip25Sh = 20;

  // Minutes are biased by 19 hours so the floor division stays unsigned.
  localparam logic [11:0] MinBias   = 12'd1140;
  localparam logic [6:0]  HourBias  = 7'd19;
  localparam logic [10:0] Recip60   = 11'd1092;
  localparam int unsigned Recip60Sh = 16;

  // Beat split: one beat is 86400 ms.
  localparam logic [16:0] MsPerBeat   = 17'd86400;
  localparam logic [10:0] RecipBeat   = 11'd1553;
  localparam int unsigned RecipBeatSh = 27;
  localparam logic [10:0] BeatsPerDay = 11'd1000;

  // Thousandths: r * 1000 / 86400 reduces to r * 5 / 432.
  localparam logic [8:0]  FracDiv     = 9'd432;
  localparam logic [10:0] RecipFrac   = 11'd1213;
  localparam int unsigned RecipFracSh = 19;

  // Transaction between the calendar stages and the beat stages.
  typedef struct packed {
    logic [TimeW-1:0] ms_of_day;
    logic [DayW-1:0]  day;
    logic             invalid;
  } lttb_time_t;

  // Days before the first of each month in a common year.
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] month);
    logic [8:0] off;
    case (month)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

/* rtl/core/lttb_beat.sv */
// Beat stages of the local time to beat time converter.
// Splits the millisecond of day into beat and thousandths over five
// pipeline stages; depends on lttb_pkg.
module lttb_beat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  lttb_pkg::lttb_time_t          time_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [lttb_pkg::DayW-1:0]     day_number_o,
  output logic [lttb_pkg::BeatW-1:0]    beat_number_o,
  output logic [lttb_pkg::BeatW-1:0]    beat_thousandths_o,
  output logic                          month_invalid_o
);

  // Stage valids and enables; a stage moves when it is empty or its
  // successor moves, so bubbles are squeezed out.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5     = !v5_q || !stall_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: beat estimate by reciprocal, low by at most one.
  logic [37:0]                  beat_prod;
  logic [10:0]                  q1_d, q1_q;
  logic [lttb_pkg::TimeW-1:0]   t1_q;
  logic [lttb_pkg::DayW-1:0]    day1_q;
  logic                         inv1_q;

  assign beat_prod = 38'(time_i.ms_of_day) * 38'(lttb_pkg::RecipBeat);
  assign q1_d      = beat_prod[37:lttb_pkg::RecipBeatSh];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q   <= time_i.ms_of_day;
      q1_q   <= q1_d;
      day1_q <= time_i.day;
      inv1_q <= time_i.invalid;
    end
  end

  // Stage 2: remainder against the estimate, below two beats.
  logic [lttb_pkg::TimeW-1:0]   r2_full;
  logic [17:0]                  r2_d, r2_q;
  logic [10:0]                  q2_q;
  logic [lttb_pkg::DayW-1:0]    day2_q;
  logic                         inv2_q;

  assign r2_full = t1_q - (27'(q1_q) * 27'(lttb_pkg::MsPerBeat));
  assign r2_d    = r2_full[17:0];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      r2_q   <= r2_d;
      q2_q   <= q1_q;
      day2_q <= day1_q;
      inv2_q <= inv1_q;
    end
  end

  // Stage 3: correct the estimate, wrap a full day of beats, scale by five.
  logic                         beat_ge;
  logic [16:0]                  r3;
  logic [10:0]                  q3;
  logic [lttb_pkg::BeatW-1:0]   beat3_d, beat3_q;
  logic [18:0]                  x3_d, x3_q;
  logic [lttb_pkg::DayW-1:0]    day3_q;
  logic                         inv3_q;

  assign beat_ge = r2_q >= 18'(lttb_pkg::MsPerBeat);
  assign r3      = beat_ge ? 17'(r2_q - 18'(lttb_pkg::MsPerBeat)) : r2_q[16:0];
  assign q3      = q2_q + 11'(beat_ge);
  assign beat3_d = (q3 == lttb_pkg::BeatsPerDay) ? '0 : q3[lttb_pkg::BeatW-1:0];
  assign x3_d    = (19'(r3) << 2) + 19'(r3);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      beat3_q <= beat3_d;
      x3_q    <= x3_d;
      day3_q  <= day2_q;
      inv3_q  <= inv2_q;
    end
  end

  // Stage 4: thousandths estimate by reciprocal of 432.
  logic [28:0]                  frac_prod;
  logic [lttb_pkg::BeatW-1:0]   fq4_d, fq4_q;
  logic [18:0]                  x4_q;
  logic [lttb_pkg::BeatW-1:0]   beat4_q;
  logic [lttb_pkg::DayW-1:0]    day4_q;
  logic                         inv4_q;

  assign frac_prod = 29'(x3_q) * 29'(lttb_pkg::RecipFrac);
  assign fq4_d     = frac_prod[28:lttb_pkg::RecipFracSh];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      fq4_q   <= fq4_d;
      x4_q    <= x3_q;
      beat4_q <= beat3_q;
      day4_q  <= day3_q;
      inv4_q  <= inv3_q;
    end
  end

  // Stage 5: correct the thousandths and hold the result transaction.
  logic [18:0]                  rf;
  logic [lttb_pkg::BeatW-1:0]   frac5_d, frac5_q;
  logic [lttb_pkg::BeatW-1:0]   beat5_q;
  logic [lttb_pkg::DayW-1:0]    day5_q;
  logic                         inv5_q;

  assign rf      = x4_q - (19'(fq4_q) * 19'(lttb_pkg::FracDiv));
  assign frac5_d = fq4_q + 10'(rf >= 19'(lttb_pkg::FracDiv));

  always_ff @(posedge clk_i) begin
    if (en5) begin
      frac5_q <= frac5_d;
      beat5_q <= beat4_q;
      day5_q  <= day4_q;
      inv5_q  <= inv4_q;
    end
  end

  assign valid_o            = v5_q;
  assign day_number_o       = day5_q;
  assign beat_number_o      = beat5_q;
  assign beat_thousandths_o = frac5_q;
  assign month_invalid_o    = inv5_q;

endmodule

/* rtl/core/local_time_to_beat_time.sv */
// Top level of the local time to beat time converter.
// Calendar and offset stages feeding lttb_beat; depends on lttb_pkg.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i/in_stall_o   year .. millisecond
//   result   out        out_valid_o/out_stall_i day, beat, thousandths, flag
//   config   in         cfg_we_i                cfg_index_i, cfg_data_i
//
// Ten register stages, five here and five in lttb_beat: one transaction
// enters every cycle while in_stall_o is low.
// Reset clears the stage valid bits and the configuration registers.
// A stalled result holds the last stage; earlier stages keep filling
// until the first occupied stage backs up to the input.
module local_time_to_beat_time (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lttb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lttb_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lttb_pkg::YearW-1:0]       year_i,
  input  logic [lttb_pkg::MonthW-1:0]      month_i,
  input  logic [lttb_pkg::DomW-1:0]        day_of_month_i,
  input  logic [lttb_pkg::HourW-1:0]       hour_i,
  input  logic [lttb_pkg::MinW-1:0]        minute_i,
  input  logic [lttb_pkg::SecW-1:0]        second_i,
  input  logic [lttb_pkg::MsW-1:0]         millisecond_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lttb_pkg::DayW-1:0]        day_number_o,
  output logic [lttb_pkg::BeatW-1:0]       beat_number_o,
  output logic [lttb_pkg::BeatW-1:0]       beat_thousandths_o,
  output logic                             month_invalid_o
);

  // Configuration registers.
  logic [lttb_pkg::CfgDataW-1:0] west_q;
  logic                          dst_q;
  logic                          plus_one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q     <= '0;
      dst_q      <= 1'b0;
      plus_one_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lttb_pkg::CFG_WEST_OFFSET: west_q     <= cfg_data_i;
        lttb_pkg::CFG_DST_ACTIVE:  dst_q      <= cfg_data_i[0];
        lttb_pkg::CFG_PLUS_ONE:    plus_one_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage control; the beat stages stall stage 5.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic beat_stall;

  assign en5        = !v5_q || !beat_stall;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: month table, year/25 estimate, shifted minutes and hours.
  logic [29:0]                   y_prod;
  logic [9:0]                    q25_d, q25_q;
  logic                          mon_ok;
  logic [11:0]                   mins1_d, mins1_q;
  logic [5:0]                    hrs1_d, hrs1_q;
  logic [lttb_pkg::YearW-1:0]    year1_q;
  logic [8:0]                    moff1_q;
  logic                          late1_q;
  logic                          inv1_q;
  logic [lttb_pkg::DomW-1:0]     dom1_q;
  logic [lttb_pkg::SecW-1:0]     sec1_q;
  logic [lttb_pkg::MsW-1:0]      ms1_q;

  assign y_prod  = 30'(year_i) * 30'(lttb_pkg::Recip25);
  assign q25_d   = y_prod[29:lttb_pkg::Recip25Sh];
  assign mon_ok  = (month_i >= 4'd1) && (month_i <= 4'd12);
  // Twelve-bit two's complement: minute + west offset - daylight hour.
  assign mins1_d = 12'(minute_i) + {west_q[lttb_pkg::CfgDataW-1], west_q}
                   - (dst_q ? 12'd60 : 12'd0);
  assign hrs1_d  = 6'(hour_i) + 6'(plus_one_q);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      year1_q <= year_i;
      q25_q   <= q25_d;
      moff1_q <= lttb_pkg::month_start(month_i);
      late1_q <= mon_ok && (month_i >= 4'd3);
      inv1_q  <= !mon_ok;
      dom1_q  <= day_of_month_i;
      mins1_q <= mins1_d;
      hrs1_q  <= hrs1_d;
      sec1_q  <= second_i;
      ms1_q   <= millisecond_i;
    end
  end

  // Stage 2: leap test, zero-based day of year, minute/60 estimate.
  logic [lttb_pkg::YearW-1:0]    r25;
  logic                          by25;
  logic                          leap;
  logic [9:0]                    iday2_d, iday2_q;
  logic [11:0]                   mb2_d, mb2_q;
  logic [22:0]                   m_prod;
  logic [6:0]                    qm2_d, qm2_q;
  logic [5:0]                    hrs2_q;
  logic                          inv2_q;
  logic [lttb_pkg::SecW-1:0]     sec2_q;
  logic [lttb_pkg::MsW-1:0]      ms2_q;

  assign r25     = year1_q - (14'(q25_q) * 14'd25);
  assign by25    = (r25 == 14'd0) || (r25 == 14'd25);
  // Divisible by 4 and not by 100, or divisible by 400 (4*25 and 16*25).
  assign leap    = (year1_q[1:0] == 2'd0) && (!by25 || (year1_q[3:0] == 4'd0));
  assign iday2_d = 10'(dom1_q) + 10'(moff1_q) + 10'(late1_q && leap) - 10'd1;
  assign mb2_d   = mins1_q + lttb_pkg::MinBias;
  assign m_prod  = 23'(mb2_d) * 23'(lttb_pkg::Recip60);
  assign qm2_d   = m_prod[22:lttb_pkg::Recip60Sh];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      iday2_q <= iday2_d;
      mb2_q   <= mb2_d;
      qm2_q   <= qm2_d;
      hrs2_q  <= hrs1_q;
      inv2_q  <= inv1_q;
      sec2_q  <= sec1_q;
      ms2_q   <= ms1_q;
    end
  end

  // Stage 3: finish minute mod 60 and carry into the hour.
  logic [11:0]                   rm_full;
  logic [6:0]                    rm_raw;
  logic                          rm_ge;
  logic [lttb_pkg::MinW-1:0]     min3_d, min3_q;
  logic [6:0]                    qm_fix;
  logic [6:0]                    hh3_d, hh3_q;
  logic [9:0]                    iday3_q;
  logic                          inv3_q;
  logic [lttb_pkg::SecW-1:0]     sec3_q;
  logic [lttb_pkg::MsW-1:0]      ms3_q;

  assign rm_full = mb2_q - (12'(qm2_q) * 12'd60);
  assign rm_raw  = rm_full[6:0];
  assign rm_ge   = rm_raw >= 7'd60;
  assign min3_d  = rm_ge ? 6'(rm_raw - 7'd60) : rm_raw[5:0];
  assign qm_fix  = qm2_q + 7'(rm_ge);
  // Signed hour before the day carry, -19 to 50.
  assign hh3_d   = 7'(hrs2_q) + qm_fix - lttb_pkg::HourBias;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      min3_q  <= min3_d;
      hh3_q   <= hh3_d;
      iday3_q <= iday2_q;
      inv3_q  <= inv2_q;
      sec3_q  <= sec2_q;
      ms3_q   <= ms2_q;
    end
  end

  // Stage 4: hour mod 24 with day carry, clamp the day, second of day.
  logic [6:0]                    hb;
  logic [4:0]                    h4;
  logic [1:0]                    day_inc;
  logic [9:0]                    dsum;
  logic [lttb_pkg::DayW-1:0]     day4_d, day4_q;
  logic [16:0]                   sod4_d, sod4_q;
  logic                          inv4_q;
  logic [lttb_pkg::MsW-1:0]      ms4_q;

  assign hb = hh3_q + 7'd24;

  // Day increment is the hour carry plus the one-based day offset.
  always_comb begin
    if (hb < 7'd24) begin
      h4      = hb[4:0];
      day_inc = 2'd0;
    end else if (hb < 7'd48) begin
      h4      = 5'(hb - 7'd24);
      day_inc = 2'd1;
    end else if (hb < 7'd72) begin
      h4      = 5'(hb - 7'd48);
      day_inc = 2'd2;
    end else begin
      h4      = 5'(hb - 7'd72);
      day_inc = 2'd3;
    end
  end

  assign dsum   = iday3_q + 10'(day_inc);
  assign day4_d = dsum[9] ? '0 : dsum[lttb_pkg::DayW-1:0];
  assign sod4_d = (17'(h4) * 17'd3600) + (17'(min3_q) * 17'd60) + 17'(sec3_q);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      day4_q <= day4_d;
      sod4_q <= sod4_d;
      inv4_q <= inv3_q;
      ms4_q  <= ms3_q;
    end
  end

  // Stage 5: millisecond of day.
  lttb_pkg::lttb_time_t time5_d, time5_q;

  always_comb begin
    time5_d.ms_of_day = (27'(sod4_q) * 27'd1000) + 27'(ms4_q);
    time5_d.day       = day4_q;
    time5_d.invalid   = inv4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      time5_q <= time5_d;
    end
  end

  // Beat and thousandths stages, holding the result transaction.
  lttb_beat u_beat (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (v5_q),
    .stall_o            (beat_stall),
    .time_i             (time5_q),
    .valid_o            (out_valid_o),
    .stall_i            (out_stall_i),
    .day_number_o       (day_number_o),
    .beat_number_o      (beat_number_o),
    .beat_thousandths_o (beat_thousandths_o),
    .month_invalid_o    (month_invalid_o)
  );

endmodule
